// ----- design/flow_window_bandwidth_alert_macros.svh -----
// Assertion macros used by the controller of the flow bandwidth detector.
`ifndef FLOW_WINDOW_BANDWIDTH_ALERT_MACROS_SVH
`define FLOW_WINDOW_BANDWIDTH_ALERT_MACROS_SVH
`ifndef SYNTHESIS
`define FWBA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FWBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FWBA_ASSERT(lbl, clk, rstn, prop, msg)
`define FWBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- design/fwba_pkg.sv -----
`default_nettype none
package fwba_pkg;

    localparam int FLOW_SLOTS = 1024;
    localparam int SLOT_BITS = $clog2(FLOW_SLOTS);
    localparam int MAX_WINDOW = 8;
    localparam int LANE_BITS = $clog2(MAX_WINDOW);
    localparam int BYTES_W = 40;
    localparam int ACC_W = BYTES_W + LANE_BITS;
    localparam int RATE_W = 48;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS = RATE_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [3:0] WINDOW_RESET = 4'd5;
    localparam logic [31:0] THRESHOLD_RESET = 32'd5000000;
    localparam logic [15:0] LINK_HEADER_BYTES = 16'd14;
    localparam logic [BYTES_W-1:0] BUCKET_MAX = {BYTES_W{1'b1}};

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [31:0] arrival_sec;
        logic [15:0] ip_length;
    } in_word_t;

    typedef struct packed {
        logic        alert;
        logic        collision;
        logic [31:0] flow_src;
        logic [31:0] flow_dst;
        logic [47:0] rate_bps;
    } out_word_t;

    typedef struct packed {
        logic [31:0]        second;
        logic [BYTES_W-1:0] bytes;
    } bucket_t;

    typedef struct packed {
        logic                        valid;
        logic [MAX_WINDOW-1:0]       used;
        logic [63:0]                 key;
        bucket_t [MAX_WINDOW-1:0]    bkt;
    } row_t;

    typedef struct packed {
        logic                  clear;
        logic [SLOT_BITS-1:0]  clr_addr;
        logic                  accept;
        logic                  update;
        logic                  sum_en;
        logic [LANE_BITS-1:0]  sum_lane;
        logic                  div_init;
        logic                  div_step;
        logic                  load_out;
    } cmd_t;

    typedef struct packed {
        logic collision;
    } status_t;

endpackage
`default_nettype wire

// ----- design/fwba_ram.sv -----
`default_nettype none
module fwba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/fwba_ctrl.sv -----
`default_nettype none
`include "flow_window_bandwidth_alert_macros.svh"
module fwba_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire fwba_pkg::status_t status,
    output fwba_pkg::cmd_t       cmd
);
    import fwba_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_SUM    = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_BITS-1:0]  clr_reg, clr_next;
    logic [LANE_BITS-1:0]  lane_reg, lane_next;
    logic [DIV_CNT_W-1:0]  div_reg, div_next;
    logic                  mv_reg, mv_next;
    logic                  out_free;

    assign out_free = !mv_reg || m_ready;
    assign m_valid  = mv_reg;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        lane_next  = lane_reg;
        div_next   = div_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        cmd.clr_addr = clr_reg;
        cmd.sum_lane = lane_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                lane_next  = '0;
                div_next   = '0;
                state_next = status.collision ? ST_DONE : ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                lane_next  = lane_reg + 1'b1;
                if (&lane_reg) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_init = (div_reg == '0);
                cmd.div_step = (div_reg != '0);
                div_next     = div_reg + 1'b1;
                if (div_reg == DIV_CNT_W'(DIV_STEPS)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            lane_reg  <= '0;
            div_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            lane_reg  <= lane_next;
            div_reg   <= div_next;
            mv_reg    <= mv_next;
        end
    end

    `FWBA_ASSERT(a_accept_to_update, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == ST_UPDATE), "accepted word did not start an update")
    `FWBA_ASSERT(a_no_accept_clear, aclk, aresetn, (state_reg == ST_CLEAR) |-> !cmd.update && !cmd.load_out, "work started during the clearing pass")
    `FWBA_ASSERT(a_div_to_done, aclk, aresetn, (state_reg == ST_DIV && div_reg == DIV_CNT_W'(DIV_STEPS)) |=> (state_reg == ST_DONE), "divider did not finish in time")
    `FWBA_ASSERT(a_load_free, aclk, aresetn, cmd.load_out |-> (!mv_reg || m_ready), "result overwrote a waiting word")

endmodule
`default_nettype wire

// ----- design/fwba_dp.sv -----
`default_nettype none
module fwba_dp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire fwba_pkg::in_word_t   s_data,
    output fwba_pkg::out_word_t       m_data,
    input  wire fwba_pkg::cmd_t       cmd,
    output fwba_pkg::status_t         status,
    output logic                      ram_we,
    output logic [fwba_pkg::SLOT_BITS-1:0] ram_waddr,
    output fwba_pkg::row_t            ram_wdata,
    output logic [fwba_pkg::SLOT_BITS-1:0] ram_raddr,
    input  wire fwba_pkg::row_t       ram_rdata
);
    import fwba_pkg::*;

    logic [3:0]           win_reg;
    logic [31:0]          thr_reg;
    in_word_t             in_reg;
    row_t                 row_reg;
    logic                 coll_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [RATE_W-1:0]    q_reg, q_next;
    logic [3:0]           rem_reg, rem_next;
    out_word_t            out_reg;

    logic [3:0]           w_eff;
    logic [63:0]          key;
    logic                 coll;
    logic [MAX_WINDOW-1:0] used0, keep;
    logic [LANE_BITS-1:0] pos;
    logic                 fresh;
    logic [BYTES_W-1:0]   base_bytes;
    logic [BYTES_W:0]     add_bytes;
    row_t                 new_row;
    logic [RATE_W-1:0]    bits;
    logic [35:0]          limit;
    logic [4:0]           r5;

    // A window of zero counts as one second, anything above the ring as the ring.
    always_comb begin
        if (win_reg == 4'd0) begin
            w_eff = 4'd1;
        end else if (win_reg > 4'(MAX_WINDOW)) begin
            w_eff = 4'(MAX_WINDOW);
        end else begin
            w_eff = win_reg;
        end
    end

    assign key       = {in_reg.src_ip, in_reg.dst_ip};
    assign coll      = ram_rdata.valid && (ram_rdata.key != key);
    assign used0     = ram_rdata.valid ? ram_rdata.used : '0;
    assign pos       = in_reg.arrival_sec[LANE_BITS-1:0];
    assign status.collision = coll;

    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            keep[i] = used0[i] && (({1'b0, ram_rdata.bkt[i].second} + 33'(w_eff))
                                   > {1'b0, in_reg.arrival_sec});
        end
        fresh      = !keep[pos] || (ram_rdata.bkt[pos].second != in_reg.arrival_sec);
        base_bytes = fresh ? '0 : ram_rdata.bkt[pos].bytes;
        add_bytes  = {1'b0, base_bytes} + (BYTES_W+1)'(in_reg.ip_length)
                     + (BYTES_W+1)'(LINK_HEADER_BYTES);
        new_row       = ram_rdata;
        new_row.valid = 1'b1;
        new_row.key   = key;
        new_row.used  = keep | (MAX_WINDOW'(1) << pos);
        new_row.bkt[pos].second = in_reg.arrival_sec;
        new_row.bkt[pos].bytes  = add_bytes[BYTES_W] ? BUCKET_MAX : add_bytes[BYTES_W-1:0];
    end

    assign ram_raddr = SLOT_BITS'(s_data.src_ip ^ s_data.dst_ip);
    assign ram_we    = cmd.clear || (cmd.update && !coll);
    assign ram_waddr = cmd.clear ? cmd.clr_addr : SLOT_BITS'(in_reg.src_ip ^ in_reg.dst_ip);
    assign ram_wdata = cmd.clear ? '0 : new_row;

    // Four quotient bits per cycle; the remainder stays below the window.
    always_comb begin
        q_next   = q_reg;
        rem_next = rem_reg;
        r5       = '0;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            r5     = {rem_next, q_next[RATE_W-1]};
            q_next = {q_next[RATE_W-2:0], (r5 >= {1'b0, w_eff})};
            rem_next = (r5 >= {1'b0, w_eff}) ? 4'(r5 - {1'b0, w_eff}) : r5[3:0];
        end
    end

    assign bits  = RATE_W'({acc_reg, 3'b000});
    assign limit = thr_reg * w_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WINDOW_RESET;
            thr_reg <= THRESHOLD_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_WINDOW) begin
                win_reg <= cfg_data[3:0];
            end else begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_reg <= s_data;
        end
        if (cmd.update) begin
            row_reg  <= new_row;
            coll_reg <= coll;
            acc_reg  <= '0;
        end
        if (cmd.sum_en && row_reg.used[cmd.sum_lane]) begin
            acc_reg <= acc_reg + ACC_W'(row_reg.bkt[cmd.sum_lane].bytes);
        end
        if (cmd.div_init) begin
            q_reg   <= bits;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
        if (cmd.load_out) begin
            out_reg.flow_src  <= in_reg.src_ip;
            out_reg.flow_dst  <= in_reg.dst_ip;
            out_reg.collision <= coll_reg;
            out_reg.alert     <= !coll_reg && (bits > RATE_W'(limit));
            out_reg.rate_bps  <= coll_reg ? '0 : q_reg;
        end
    end

    assign m_data = out_reg;

endmodule
`default_nettype wire

// ----- design/flow_window_bandwidth_alert.sv -----
// Per-flow sliding-window bandwidth detector.
// Packet words enter on the s_ channel (valid/ready) carrying source and
// destination address, a whole-second timestamp and the IP length. Each word
// produces exactly one result word on the m_ channel: the flow addresses, the
// window rate in bits per second, an alert flag and a collision flag.
// The flow table is one row per slot in a single RAM, read once per word and
// written back for each counted word. A counted packet passes through an
// update step, a bucket summation over the eight ring lanes and the radix-16
// window divider before its result is loaded into the output register; a
// collision goes from the update step straight to the output. One word is in
// flight at a time: a new word is taken only after the last result has been
// loaded into the output register.
// After reset the block runs a clearing pass over all 1024 rows of the flow
// table with s_ready low; configuration writes are taken throughout.
// Results sit in an output register; the next word may be accepted while a
// result waits, and a stalled receiver holds the following result back in
// the datapath until the register frees up.
`default_nettype none
module flow_window_bandwidth_alert (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire fwba_pkg::in_word_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output fwba_pkg::out_word_t       m_data
);
    import fwba_pkg::*;

    cmd_t                 cmd;
    status_t              status;
    logic                 ram_we;
    logic [SLOT_BITS-1:0] ram_waddr;
    logic [SLOT_BITS-1:0] ram_raddr;
    row_t                 ram_wdata;
    row_t                 ram_rdata;

    // The controller sequences clearing, update, summation, division and the output load.
    fwba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds configuration, the row being worked on and the result.
    fwba_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // One row per flow slot: valid, bucket-used mask, key and all ring buckets.
    fwba_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (FLOW_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ----- tb/flow_window_bandwidth_alert_test.sv -----
`default_nettype none
module flow_window_bandwidth_alert_test;
    import fwba_pkg::*;

    // Clock, reset and the ports of the block.
    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_data;

    flow_window_bandwidth_alert dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // The watchdog limit. It lies well above the slowest correct word, the
    // longest receiver stall and the clearing pass after reset, during which
    // nothing is accepted.
    localparam int IDLE_LIMIT = 20000;
    // Cycles to wait before a register write, and after the last result.
    localparam int DRAIN_CYCLES = 60;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Our own copy of the flow table and the two registers. The table is kept
    // as plain arrays indexed by slot, and by slot and ring position.
    logic [3:0]  window_reg;
    logic [31:0] threshold_reg;
    logic        slot_taken [FLOW_SLOTS];
    logic [63:0] slot_key   [FLOW_SLOTS];
    logic [7:0]  ring_used  [FLOW_SLOTS];
    logic [31:0] ring_sec   [FLOW_SLOTS][MAX_WINDOW];
    logic [39:0] ring_bytes [FLOW_SLOTS][MAX_WINDOW];

    out_word_t expected_words[$];
    int        error_count;
    int        words_sent;
    int        words_checked;
    int        alerts_seen;
    int        collisions_seen;
    int        idle_cycles;

    // Receiver control: a long hold-off is requested by the stimulus and
    // counted down in the receiver's own process.
    bit        receiver_hold;
    int        hold_cycles;
    bit        allow_gaps;

    // Time stream of the random traffic; nondecreasing across the run.
    logic [31:0] clock_now;

    // Works out the result of one packet and updates the flow table.
    function automatic out_word_t predict_flow(in_word_t pkt);
        out_word_t    r;
        logic [63:0]  key;
        logic [9:0]   slot;
        logic [63:0]  w;
        logic [2:0]   pos;
        logic [63:0]  total;
        logic [63:0]  bits;
        logic [63:0]  rate;
        logic [63:0]  sum_bytes;
        key  = {pkt.src_ip, pkt.dst_ip};
        slot = pkt.src_ip[9:0] ^ pkt.dst_ip[9:0];
        w    = (window_reg == 0) ? 64'd1 :
               (window_reg > MAX_WINDOW) ? 64'(MAX_WINDOW) : 64'(window_reg);
        r.flow_src = pkt.src_ip;
        r.flow_dst = pkt.dst_ip;
        if (slot_taken[slot] && slot_key[slot] != key) begin
            r.alert     = 1'b0;
            r.collision = 1'b1;
            r.rate_bps  = '0;
            return r;
        end
        if (!slot_taken[slot]) begin
            slot_taken[slot] = 1'b1;
            slot_key[slot]   = key;
            ring_used[slot]  = '0;
        end
        // Buckets at or before now minus the window leave the ring.
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (ring_used[slot][i] && !(64'(ring_sec[slot][i]) + w > 64'(pkt.arrival_sec)))
                ring_used[slot][i] = 1'b0;
        end
        pos = pkt.arrival_sec[2:0];
        if (!ring_used[slot][pos] || ring_sec[slot][pos] != pkt.arrival_sec) begin
            ring_used[slot][pos]  = 1'b1;
            ring_sec[slot][pos]   = pkt.arrival_sec;
            ring_bytes[slot][pos] = '0;
        end
        sum_bytes = 64'(ring_bytes[slot][pos]) + 64'(pkt.ip_length) + 64'd14;
        ring_bytes[slot][pos] = (sum_bytes > 64'(BUCKET_MAX)) ? BUCKET_MAX : sum_bytes[39:0];
        total = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (ring_used[slot][i] && (64'(ring_sec[slot][i]) + w > 64'(pkt.arrival_sec)))
                total += 64'(ring_bytes[slot][i]);
        end
        bits = total * 8;
        rate = bits / w;
        r.rate_bps  = (rate > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : rate[47:0];
        r.alert     = bits > 64'(threshold_reg) * w;
        r.collision = 1'b0;
        return r;
    endfunction

    // Result checker: every accepted result is compared with the oldest
    // expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: %h", m_data);
                error_count++;
            end else begin
                out_word_t e;
                e = expected_words.pop_front();
                if (m_data.alert !== e.alert) begin
                    $error("alert: expected %0d, got %0d", e.alert, m_data.alert);
                    error_count++;
                end
                if (m_data.collision !== e.collision) begin
                    $error("collision: expected %0d, got %0d", e.collision, m_data.collision);
                    error_count++;
                end
                if (m_data.flow_src !== e.flow_src) begin
                    $error("flow_src: expected %h, got %h", e.flow_src, m_data.flow_src);
                    error_count++;
                end
                if (m_data.flow_dst !== e.flow_dst) begin
                    $error("flow_dst: expected %h, got %h", e.flow_dst, m_data.flow_dst);
                    error_count++;
                end
                if (m_data.rate_bps !== e.rate_bps) begin
                    $error("rate_bps: expected %0d, got %0d", e.rate_bps, m_data.rate_bps);
                    error_count++;
                end
                words_checked++;
                if (e.alert) alerts_seen++;
                if (e.collision) collisions_seen++;
            end
        end
    end

    // Receiver: random stalls, mostly short, a few long, and stretches of
    // none; a requested hold-off overrides everything.
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (receiver_hold) begin
                m_ready = 1'b0;
                hold_cycles = $urandom_range(400, 250);
                while (hold_cycles > 0) begin
                    @(negedge aclk);
                    hold_cycles--;
                end
                receiver_hold = 1'b0;
            end
            if (!allow_gaps || $urandom_range(99) < 60) begin
                m_ready = 1'b1;
            end else begin
                gap = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
                m_ready = 1'b1;
            end
        end
    end

    // Watchdog: counts cycles with no word accepted on either side.
    always @(posedge aclk) begin
        if (s_valid && s_ready || m_valid && m_ready)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offers one packet word and waits until it is taken; the expectation is
    // computed at acceptance. An optional random gap precedes the word.
    task automatic send_packet(input in_word_t pkt);
        int gap;
        if (allow_gaps && $urandom_range(99) < 30) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(3, 1);
            repeat (gap) @(negedge aclk);
        end
        s_data  = pkt;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(predict_flow(pkt));
        words_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Waits until every result has come, plus a margin for work in flight.
    task automatic drain_results();
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Writes one register while the block is idle.
    task automatic write_register(input logic idx, input logic [31:0] value);
        drain_results();
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_WINDOW) window_reg = value[3:0];
        else threshold_reg = value;
    endtask

    function automatic in_word_t make_packet(logic [31:0] src, logic [31:0] dst,
                                             logic [31:0] sec, logic [15:0] len);
        in_word_t p;
        p.src_ip = src;
        p.dst_ip = dst;
        p.arrival_sec = sec;
        p.ip_length = len;
        return p;
    endfunction

    // Directed: field extremes, early time, new flows, collision, backwards
    // time causing a ring clash, and the window running out.
    task automatic test_directed();
        send_packet(make_packet(32'h0, 32'h0, 32'd0, 16'd0));
        send_packet(make_packet(32'h0, 32'h0, 32'd1, 16'hFFFF));
        send_packet(make_packet(32'h0, 32'h0, 32'd3, 16'd1500));
        send_packet(make_packet(32'h0, 32'h0, 32'd4, 16'd1500));
        // Same slot, different flow: the packet is not counted.
        send_packet(make_packet(32'h0000_0400, 32'h0000_0400, 32'd4, 16'd40));
        send_packet(make_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4, 16'hFFFF));
        send_packet(make_packet(32'hFFFF_FFFF, 32'h0000_0000, 32'd5, 16'd100));
        send_packet(make_packet(32'h0000_0000, 32'hFFFF_FFFF, 32'd9, 16'd100));
        // Old buckets of the first flow have left the window.
        send_packet(make_packet(32'h0, 32'h0, 32'd12, 16'd64));
        // Time runs backwards onto a ring position of a later second.
        send_packet(make_packet(32'h0, 32'h0, 32'd4, 16'd64));
        send_packet(make_packet(32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'hFFFF_FFF0, 16'd9000));
        send_packet(make_packet(32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'hFFFF_FFFF, 16'hFFFF));
        send_packet(make_packet(32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'hFFFF_FFFF, 16'hFFFF));
        drain_results();
    endtask

    // Sweeps the window register over zero, the valid range and above the
    // ring size, and the threshold over its extremes.
    task automatic test_registers();
        logic [3:0]  windows [5] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd3};
        logic [31:0] thresholds [4] = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd100000};
        for (int k = 0; k < 5; k++) begin
            write_register(REG_WINDOW, {28'h0, windows[k]});
            write_register(REG_THRESHOLD, thresholds[k % 4]);
            for (int j = 0; j < 3; j++)
                send_packet(make_packet(32'h1000 + k, 32'h2000, 32'd20 + k * 3 + j,
                                        16'($urandom_range(1500))));
        end
        drain_results();
    endtask

    // Random traffic: mostly a small set of active flows so windows fill and
    // buckets age out, plus keys on the slots of active flows that cause collisions, and random addresses.
    function automatic in_word_t random_packet();
        logic [31:0] src;
        logic [31:0] dst;
        int          r;
        r = $urandom_range(99);
        if (r < 75) begin
            src = 32'hC0A8_0000 | $urandom_range(7);
            dst = 32'h0A00_0001;
        end else if (r < 85) begin
            // Same slot as an active flow but a different key.
            src = (32'hC0A8_0000 | $urandom_range(7)) ^ ($urandom_range(255, 1) << 10);
            dst = 32'h0A00_0001;
        end else begin
            src = $urandom;
            dst = $urandom;
        end
        if ($urandom_range(99) < 30)
            clock_now = clock_now + $urandom_range(($urandom_range(9) == 0) ? 12 : 2);
        return make_packet(src, dst, clock_now,
                           ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(1500)));
    endfunction

    task automatic test_random(input int count, input logic [3:0] win, input logic [31:0] thr);
        write_register(REG_WINDOW, {28'h0, win});
        write_register(REG_THRESHOLD, thr);
        for (int n = 0; n < count; n++)
            send_packet(random_packet());
        drain_results();
    endtask

    // The receiver holds off for a long stretch while packets keep coming;
    // the sender then pauses until every result has come.
    task automatic test_backpressure();
        receiver_hold = 1'b1;
        for (int n = 0; n < 12; n++)
            send_packet(random_packet());
        drain_results();
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WINDOW;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        receiver_hold = 1'b0;
        allow_gaps = 1'b0;
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        alerts_seen = 0;
        collisions_seen = 0;
        idle_cycles = 0;
        clock_now = 32'd100;
        window_reg = WINDOW_RESET;
        threshold_reg = THRESHOLD_RESET;
        for (int s = 0; s < FLOW_SLOTS; s++) begin
            slot_taken[s] = 1'b0;
            ring_used[s] = '0;
        end
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_registers();
        allow_gaps = 1'b1;
        test_random(200, 4'd5, 32'd20000);
        test_backpressure();
        test_random(200, 4'd8, 32'd50000);
        test_random(100, 4'd1, 32'd0);
        allow_gaps = 1'b0;
        test_random(100, 4'd2, 32'hFFFF_FFFF);
        drain_results();

        $display("Sent %0d packet words over several window and threshold settings;",
                 words_sent);
        $display("checked %0d results, %0d with alert and %0d collisions.",
                 words_checked, alerts_seen, collisions_seen);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
